// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define MCB_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define MCB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/mcb_pkg.sv -----
// Types and constants shared by the bond failure check modules.
package mcb_pkg;

    typedef struct packed {
        logic valid;
        logic skip;   // unbreakable end or bond already broken
        logic conn;
    } mcb_tag_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_SHEAR   = 2'd1,
        CAUSE_TENSILE = 2'd2
    } mcb_cause_t;

    typedef enum logic [2:0] {
        CFG_COHESION = 3'd0,
        CFG_SLOPE    = 3'd1,
        CFG_COSINE   = 3'd2,
        CFG_SINE     = 3'd3,
        CFG_TENSILE  = 3'd4
    } mcb_cfg_idx_t;

    localparam int SQRT_STAGES = 32;

endpackage

// ----- design/mohr_coulomb_bond_failure_check_unit.sv -----
// Mohr-Coulomb bond failure check with tensile cutoff, top level.
//
// Input words on s_*: one bond per word, the stresses at both end particles
// plus the unbreakable and connected flags. Result words on m_*: the new
// connected flag, a broke flag and the break cause (none, shear, tension).
// Five registers are written through cfg_we/cfg_addr/cfg_wdata; write them
// only while no word is in flight. Unknown indexes are ignored.
//
// The path from input to result has four front stages, 32 square root stages
// (one root bit per stage) and four back stages, the last being the output
// register. The unit takes one word per cycle while the output is not stalled.
//
// Reset clears every valid bit and loads the register defaults (plane sine
// 1.0, all else zero). When the receiver holds m_tready low with a word in
// the output register, the whole pipeline freezes and s_tready drops; nothing
// is lost or repeated.
module mohr_coulomb_bond_failure_check_unit import mcb_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // xx_self, yy_self, xy_self, xx_other, yy_other, xy_other (32 each),
    // self_unbreakable, other_unbreakable, bond_connected, zero pad
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // bond_connected_next, bond_broke, break_cause[1:0], zero pad
    output logic [7:0]   m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    logic [30:0]        cohesion_reg;
    logic [23:0]        slope_reg;
    logic signed [17:0] cosine_reg, sine_reg;
    logic signed [31:0] tensile_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cohesion_reg <= '0;
            slope_reg    <= '0;
            cosine_reg   <= '0;
            sine_reg     <= 18'sd65536;
            tensile_reg  <= '0;
        end else if (cfg_we) begin
            case (mcb_cfg_idx_t'(cfg_addr))
                CFG_COHESION: cohesion_reg <= cfg_wdata[30:0];
                CFG_SLOPE:    slope_reg    <= cfg_wdata[23:0];
                CFG_COSINE:   cosine_reg   <= $signed(cfg_wdata[17:0]);
                CFG_SINE:     sine_reg     <= $signed(cfg_wdata[17:0]);
                CFG_TENSILE:  tensile_reg  <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    logic               adv;
    mcb_tag_t           tag_in, tag_f, tag_q, tag_o;
    logic [63:0]        sq;
    logic signed [31:0] first_f, first_q;
    logic [31:0]        root;
    logic               conn_next, broke;
    mcb_cause_t         cause;

    // advance everything unless a result waits on a stalled receiver
    assign adv      = !tag_o.valid || m_tready;
    assign s_tready = adv;

    always_comb begin
        tag_in.valid = s_tvalid;
        tag_in.skip  = s_tdata[192] | s_tdata[193] | !s_tdata[194];
        tag_in.conn  = s_tdata[194];
    end

    mcb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .tag_in  (tag_in),
        .xx_a    ($signed(s_tdata[31:0])),
        .yy_a    ($signed(s_tdata[63:32])),
        .xy_a    ($signed(s_tdata[95:64])),
        .xx_b    ($signed(s_tdata[127:96])),
        .yy_b    ($signed(s_tdata[159:128])),
        .xy_b    ($signed(s_tdata[191:160])),
        .tag_out (tag_f),
        .sq      (sq),
        .first   (first_f)
    );

    mcb_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .tag_in    (tag_f),
        .sq        (sq),
        .first_in  (first_f),
        .tag_out   (tag_q),
        .root      (root),
        .first_out (first_q)
    );

    mcb_crit #(.FRACTION_BITS(FRACTION_BITS)) u_crit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (adv),
        .tag_in           (tag_q),
        .root             (root),
        .first            (first_q),
        .cohesion         (cohesion_reg),
        .friction_slope   (slope_reg),
        .plane_cosine     (cosine_reg),
        .plane_sine       (sine_reg),
        .tensile_strength (tensile_reg),
        .tag_out          (tag_o),
        .conn_next        (conn_next),
        .broke            (broke),
        .cause            (cause)
    );

    assign m_tvalid = tag_o.valid;
    assign m_tdata  = {4'b0000, cause, broke, conn_next};
endmodule

// ----- design/mcb_front.sv -----
// Front stages: stress averaging, center and radius terms, squares and their sum.
module mcb_front import mcb_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  mcb_tag_t           tag_in,
    input  logic signed [31:0] xx_a,
    input  logic signed [31:0] yy_a,
    input  logic signed [31:0] xy_a,
    input  logic signed [31:0] xx_b,
    input  logic signed [31:0] yy_b,
    input  logic signed [31:0] xy_b,
    output mcb_tag_t           tag_out,
    output logic [63:0]        sq,
    output logic signed [31:0] first
);
    mcb_tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic signed [31:0] sx_reg, sy_reg, sxy_reg, sxy2_reg, h_reg;
    logic signed [31:0] first2_reg, first3_reg, first4_reg;
    logic signed [63:0] hh_reg, ss_reg;
    logic [63:0] sq_reg;

    logic signed [32:0] sum_x, sum_y, sum_xy, sum_c, dif_c;

    always_comb begin
        sum_x  = {xx_a[31], xx_a} + {xx_b[31], xx_b};
        sum_y  = {yy_a[31], yy_a} + {yy_b[31], yy_b};
        sum_xy = {xy_a[31], xy_a} + {xy_b[31], xy_b};
        sum_c  = {sx_reg[31], sx_reg} + {sy_reg[31], sy_reg};
        dif_c  = {sx_reg[31], sx_reg} - {sy_reg[31], sy_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end else if (en) begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // averages round toward minus infinity: drop the low bit
            sx_reg     <= sum_x[32:1];
            sy_reg     <= sum_y[32:1];
            sxy_reg    <= sum_xy[32:1];
            first2_reg <= sum_c[32:1];
            h_reg      <= dif_c[32:1];
            sxy2_reg   <= sxy_reg;
            hh_reg     <= h_reg * h_reg;
            ss_reg     <= sxy2_reg * sxy2_reg;
            first3_reg <= first2_reg;
            sq_reg     <= $unsigned(hh_reg) + $unsigned(ss_reg);
            first4_reg <= first3_reg;
        end
    end

    assign tag_out = tag4_reg;
    assign sq      = sq_reg;
    assign first   = first4_reg;
endmodule

// ----- design/mcb_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module mcb_sqrt import mcb_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  mcb_tag_t           tag_in,
    input  logic [63:0]        sq,
    input  logic signed [31:0] first_in,
    output mcb_tag_t           tag_out,
    output logic [31:0]        root,
    output logic signed [31:0] first_out
);
    mcb_tag_t           tag_reg   [0:SQRT_STAGES-1];
    logic [63:0]        rem_reg   [0:SQRT_STAGES-1];
    logic [63:0]        res_reg   [0:SQRT_STAGES-1];
    logic signed [31:0] first_reg [0:SQRT_STAGES-1];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [63:0] BIT_K = 64'd1 << (62 - 2 * k);
        mcb_tag_t           tag_src;
        logic [63:0]        rem_src, res_src, trial, rem_next, res_next;
        logic signed [31:0] first_src;
        logic               take;

        if (k == 0) begin : g_head
            assign tag_src   = tag_in;
            assign rem_src   = sq;
            assign res_src   = '0;
            assign first_src = first_in;
        end else begin : g_body
            assign tag_src   = tag_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign res_src   = res_reg[k-1];
            assign first_src = first_reg[k-1];
        end

        always_comb begin
            trial    = res_src + BIT_K;
            take     = rem_src >= trial;
            rem_next = take ? rem_src - trial : rem_src;
            res_next = take ? (res_src >> 1) + BIT_K : res_src >> 1;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[k] <= '0;
            end else if (en) begin
                tag_reg[k] <= tag_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]   <= rem_next;
                res_reg[k]   <= res_next;
                first_reg[k] <= first_src;
            end
        end
    end

    assign tag_out   = tag_reg[SQRT_STAGES-1];
    assign root      = res_reg[SQRT_STAGES-1][31:0];
    assign first_out = first_reg[SQRT_STAGES-1];
endmodule

// ----- design/mcb_crit.sv -----
// Back stages: plane stresses, shear limit, tensile cutoff and the result register.
module mcb_crit import mcb_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  mcb_tag_t           tag_in,
    input  logic [31:0]        root,
    input  logic signed [31:0] first,
    input  logic [30:0]        cohesion,
    input  logic [23:0]        friction_slope,
    input  logic signed [17:0] plane_cosine,
    input  logic signed [17:0] plane_sine,
    input  logic signed [31:0] tensile_strength,
    output mcb_tag_t           tag_out,
    output logic               conn_next,
    output logic               broke,
    output mcb_cause_t         cause
);
    localparam int SH_W  = 50 - FRACTION_BITS;
    localparam int SC_W  = 51 - FRACTION_BITS;
    localparam int NRM_W = (SC_W > 32 ? SC_W : 32) + 1;
    localparam int PF_W  = NRM_W + 25;
    localparam int FS_W  = PF_W - FRACTION_BITS;
    localparam int LD_W  = (FS_W > 32 ? FS_W : 32) + 1;
    localparam int CMP_W = LD_W > SH_W ? LD_W : SH_W;

    mcb_tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [49:0]              prod_s_reg;
    logic signed [50:0]       prod_c_reg;
    logic signed [31:0]       first1_reg;
    logic signed [33:0]       p2_1_reg, p2_2_reg, p2_3_reg;
    logic [SH_W-1:0]          shear2_reg, shear3_reg;
    logic signed [NRM_W-1:0]  normal_reg;
    logic signed [PF_W-1:0]   prod_f_reg;
    logic                     conn_next_reg, broke_reg;
    mcb_cause_t               cause_reg;

    logic [17:0]             sine_mag;
    logic signed [SC_W-1:0]  sc;
    logic signed [FS_W-1:0]  fs;
    logic signed [LD_W-1:0]  diff;
    logic [LD_W-1:0]         lim;
    logic                    shear_hit, tens_hit;
    logic                    conn_next_next, broke_next;
    mcb_cause_t              cause_next;

    always_comb begin
        sine_mag  = plane_sine[17] ? $unsigned(18'(-plane_sine)) : $unsigned(plane_sine);
        sc        = $signed(prod_c_reg[50:FRACTION_BITS]);
        fs        = $signed(prod_f_reg[PF_W-1:FRACTION_BITS]);
        diff      = LD_W'($signed({1'b0, cohesion})) - LD_W'(fs);
        lim       = diff[LD_W-1] ? $unsigned(-diff) : $unsigned(diff);
        shear_hit = CMP_W'(shear3_reg) >= CMP_W'(lim);
        tens_hit  = p2_3_reg >= 34'(tensile_strength);

        conn_next_next = tag3_reg.conn;
        broke_next     = 1'b0;
        cause_next     = CAUSE_NONE;
        if (!tag3_reg.skip) begin
            if (shear_hit) begin
                conn_next_next = 1'b0;
                broke_next     = 1'b1;
                cause_next     = CAUSE_SHEAR;
            end else if (tens_hit) begin
                conn_next_next = 1'b0;
                broke_next     = 1'b1;
                cause_next     = CAUSE_TENSILE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end else if (en) begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_s_reg    <= root * sine_mag;
            prod_c_reg    <= $signed({1'b0, root}) * plane_cosine;
            first1_reg    <= first;
            p2_1_reg      <= 34'(first) + $signed({2'b00, root});
            shear2_reg    <= prod_s_reg[49:FRACTION_BITS];
            normal_reg    <= NRM_W'(first1_reg) - NRM_W'(sc);
            p2_2_reg      <= p2_1_reg;
            prod_f_reg    <= $signed({1'b0, friction_slope}) * normal_reg;
            shear3_reg    <= shear2_reg;
            p2_3_reg      <= p2_2_reg;
            conn_next_reg <= conn_next_next;
            broke_reg     <= broke_next;
            cause_reg     <= cause_next;
        end
    end

    assign tag_out   = tag4_reg;
    assign conn_next = conn_next_reg;
    assign broke     = broke_reg;
    assign cause     = cause_reg;
endmodule

// ----- design/mcb_checker.sv -----
// Port-level checker for the bond failure check unit, with its bind.
`include "assert_macros.svh"

module mcb_checker import mcb_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    logic       out_wait, out_conn, out_broke, cause_ok;
    mcb_cause_t out_cause;

    assign out_wait  = m_tvalid && !m_tready;
    assign out_conn  = m_tdata[0];
    assign out_broke = m_tdata[1];
    assign out_cause = mcb_cause_t'(m_tdata[3:2]);
    assign cause_ok  = (out_cause == CAUSE_NONE) || (out_cause == CAUSE_SHEAR) ||
                       (out_cause == CAUSE_TENSILE);

    `MCB_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_wait, m_tvalid && $stable(m_tdata))
    `MCB_ASSERT_IMPLY(a_broke_clears, aclk, aresetn, m_tvalid && out_broke, !out_conn)
    `MCB_ASSERT_IMPLY(a_cause_broke, aclk, aresetn, m_tvalid, out_broke == (out_cause != CAUSE_NONE))
    `MCB_ASSERT_IMPLY(a_cause_legal, aclk, aresetn, m_tvalid, cause_ok)
    `MCB_ASSERT_IMPLY(a_ready_empty, aclk, aresetn, !m_tvalid, s_tready)
endmodule

bind mohr_coulomb_bond_failure_check_unit mcb_checker u_mcb_checker (.*);

// ----- tb/tb_top.sv -----
// Testbench for the Mohr-Coulomb bond failure check unit: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb_top;
    import mcb_pkg::*;

    typedef struct packed {
        logic       connected_next;
        logic       broke;
        mcb_cause_t cause;
    } bond_verdict_t;

    // Scoreboard: computes the verdict for every accepted bond and checks results in order.
    class bond_scoreboard;
        bond_verdict_t    pending[$];
        int               errors;
        logic [30:0]      cohesion;
        logic [23:0]      slope;
        logic signed [17:0] cosine;
        logic signed [17:0] sine;
        logic signed [31:0] tensile;

        function new();
            errors = 0;
            cohesion = 0;
            slope = 0;
            cosine = 0;
            sine = 18'sd65536;
            tensile = 0;
        endfunction

        function void write_reg(mcb_cfg_idx_t idx, logic [31:0] v);
            case (idx)
                CFG_COHESION: cohesion = v[30:0];
                CFG_SLOPE:    slope = v[23:0];
                CFG_COSINE:   cosine = v[17:0];
                CFG_SINE:     sine = v[17:0];
                CFG_TENSILE:  tensile = v;
                default: ;
            endcase
        endfunction

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_bond(logic [199:0] d);
            bond_verdict_t      v;
            longint             sx, sy, sxy, first, h, second, p2, shear, normal, lim;
            longint             asine;
            longint unsigned    sq;
            v.connected_next = d[194];
            v.broke = 0;
            v.cause = CAUSE_NONE;
            if (!(d[192] | d[193]) && d[194]) begin
                sx = ($signed({{32{d[31]}}, d[31:0]}) + $signed({{32{d[127]}}, d[127:96]})) >>> 1;
                sy = ($signed({{32{d[63]}}, d[63:32]}) +
                      $signed({{32{d[159]}}, d[159:128]})) >>> 1;
                sxy = ($signed({{32{d[95]}}, d[95:64]}) +
                       $signed({{32{d[191]}}, d[191:160]})) >>> 1;
                first = (sx + sy) >>> 1;
                h = (sx - sy) >>> 1;
                sq = h * h + sxy * sxy;
                second = longint'(int_sqrt(sq));
                p2 = first + second;
                asine = sine < 0 ? -longint'(sine) : longint'(sine);
                shear = (second * asine) >>> 16;
                normal = first - ((second * longint'(cosine)) >>> 16);
                lim = longint'({33'd0, cohesion}) - ((longint'({40'd0, slope}) * normal) >>> 16);
                if (lim < 0) lim = -lim;
                if (shear >= lim) begin
                    v = '{1'b0, 1'b1, CAUSE_SHEAR};
                end else if (p2 >= longint'(tensile)) begin
                    v = '{1'b0, 1'b1, CAUSE_TENSILE};
                end
            end
            pending = {pending, v};
        endfunction

        function void check_verdict(logic [7:0] d);
            bond_verdict_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", d);
                return;
            end
            e = pending.pop_front();
            if (d[0] !== e.connected_next || d[1] !== e.broke || d[3:2] !== e.cause) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected conn=%0d broke=%0d cause=%0d, got %h",
                             e.connected_next, e.broke, e.cause, d);
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_wdata;

    bond_scoreboard sb;
    bit  src_calm;
    bit  sink_calm;
    bit  sink_hold;
    int  quiet_cycles;

    localparam int LATENCY = 40;
    localparam int QUIET_LIMIT = 20000;

    mohr_coulomb_bond_failure_check_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_we = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        src_calm = 0;
        sink_calm = 0;
        sink_hold = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
    end

    // Result side: random stalls, a calm stretch, and a long hold-off on request.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
            m_tready <= !sink_hold && (sink_calm || $urandom_range(99) >= 21);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(mcb_cfg_idx_t idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        sb.write_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Offer one bond word and hold it until the handshake.
    task automatic send_bond(logic [199:0] d);
        while (!src_calm && $urandom_range(99) < 21) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_bond(d);
    endtask

    function automatic logic [31:0] rand_stress();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return 32'($signed($urandom_range(200000000)) - 100000000);
        endcase
    endfunction

    function automatic logic [199:0] rand_bond(bit breakable);
        logic [199:0] d;
        d = '0;
        for (int i = 0; i < 6; i++) d[i*32 +: 32] = rand_stress();
        if (breakable) begin
            d[194] = 1;
            d[193:192] = ($urandom_range(9) == 0) ? 2'($urandom()) : 2'b00;
        end else begin
            d[194:192] = 3'($urandom());
        end
        return d;
    endfunction

    task automatic rand_config();
        write_reg(CFG_COHESION, $urandom_range(2) == 0 ? 32'h7fffffff : $urandom_range(8000000));
        write_reg(CFG_SLOPE, $urandom_range(3) == 0 ? 32'hffffff : $urandom_range(120000));
        write_reg(CFG_COSINE, 32'($signed($urandom_range(131072)) - 65536));
        write_reg(CFG_SINE, 32'($signed($urandom_range(131072)) - 65536));
        write_reg(CFG_TENSILE, $urandom_range(3) == 0 ? $urandom() :
                  32'($signed($urandom_range(20000000)) - 10000000));
        write_reg(mcb_cfg_idx_t'(3'd5 + 3'($urandom_range(2))), $urandom());
    endtask

    initial begin
        logic [199:0] d;
        @(posedge aresetn);
        @(posedge aclk);
        // Directed: reset settings, extremes, skip cases.
        send_bond({5'b0, 3'b100, {6{32'h7fffffff}}});
        send_bond({5'b0, 3'b100, {6{32'h80000000}}});
        send_bond({5'b0, 3'b100, 192'd0});
        send_bond({5'b0, 3'b000, {6{32'h12345678}}});
        send_bond({5'b0, 3'b101, {6{32'h80000000}}});
        send_bond({5'b0, 3'b110, {6{32'h7fffffff}}});
        send_bond({5'b0, 3'b011, {6{32'hffffffff}}});
        send_bond({5'b0, 3'b100, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h7fffffff, 32'h80000000, 32'h7fffffff});
        drain();
        write_reg(CFG_COHESION, 32'h7fffffff);
        write_reg(CFG_SLOPE, 32'hffffff);
        write_reg(CFG_COSINE, 32'hfffe0000);
        write_reg(CFG_SINE, 32'hfffe0000);
        write_reg(CFG_TENSILE, 32'h80000000);
        write_reg(mcb_cfg_idx_t'(3'd7), 32'hffffffff);
        for (int i = 0; i < 6; i++) send_bond(rand_bond(1));
        send_bond({5'b0, 3'b100, {6{32'h80000000}}});
        drain();
        write_reg(CFG_COSINE, 32'h00010000);
        write_reg(CFG_SINE, 32'h00010000);
        write_reg(CFG_TENSILE, 32'h7fffffff);
        write_reg(CFG_SLOPE, 32'd0);
        write_reg(CFG_COHESION, 32'd0);
        for (int i = 0; i < 6; i++) send_bond(rand_bond(1));
        drain();
        // Random phases with fresh settings.
        for (int ph = 0; ph < 14; ph++) begin
            rand_config();
            src_calm = (ph == 3);
            sink_calm = (ph == 3);
            if (ph == 6) begin
                fork
                    begin
                        sink_hold = 1;
                        repeat (300) @(posedge aclk);
                        sink_hold = 0;
                    end
                join_none
            end
            for (int i = 0; i < 100; i++) begin
                send_bond(rand_bond($urandom_range(3) != 0));
                // Pause until every result has come in.
                if (ph == 9 && i == 50) begin
                    s_tvalid <= 0;
                    while (sb.pending.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end
        src_calm = 0;
        sink_calm = 0;
        if (sb.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/mcb_pkg.sv
design/mcb_front.sv
design/mcb_sqrt.sv
design/mcb_crit.sv
design/mohr_coulomb_bond_failure_check_unit.sv
design/mcb_checker.sv
tb/tb_top.sv
